// File: hdl/hrf_pkg.sv
// Shared types, constants and match-pattern functions for the HTTP request framer.
package hrf_pkg;

  // Width of the content-length accumulator and body counter
  localparam int unsigned LENGTH_BITS   = 32;
  localparam int unsigned BODY_LEN_BITS = 32;
  localparam int unsigned HDR_LEN       = 15;

  localparam logic [LENGTH_BITS-1:0] LEN_MAX = '1;

  localparam logic [7:0] CH_CR    = 8'h0d;
  localparam logic [7:0] CH_LF    = 8'h0a;
  localparam logic [7:0] CH_G     = 8'h47;
  localparam logic [7:0] CH_P     = 8'h50;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_UP_A  = 8'h41;
  localparam logic [7:0] CH_UP_Z  = 8'h5a;

  typedef enum logic [2:0] {
    ST_IDLE   = 3'd0,
    ST_METHOD = 3'd1,
    ST_HEADER = 3'd2,
    ST_BODY   = 3'd3,
    ST_DROP   = 3'd4
  } stage_e;

  typedef enum logic {
    METHOD_GET  = 1'b0,
    METHOD_POST = 1'b1
  } method_e;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       segment_last;
  } in_t;

  typedef struct packed {
    logic [7:0]               out_byte;
    logic                     in_request;
    logic                     request_end;
    logic                     dropped;
    logic [BODY_LEN_BITS-1:0] body_length;
  } out_t;

  // ASCII upper case to lower case
  function automatic logic [7:0] to_lower(input logic [7:0] c);
    logic [7:0] r;
    r = c;
    if (c >= CH_UP_A && c <= CH_UP_Z) begin
      r = c + 8'd32;
    end
    return r;
  endfunction

  // Method pattern: "GET " or "POST "
  function automatic logic [7:0] method_char(input method_e kind, input logic [2:0] pos);
    logic [7:0] r;
    r = 8'h00;
    if (kind == METHOD_POST) begin
      case (pos)
        3'd0:    r = "P";
        3'd1:    r = "O";
        3'd2:    r = "S";
        3'd3:    r = "T";
        3'd4:    r = " ";
        default: r = 8'h00;
      endcase
    end else begin
      case (pos)
        3'd0:    r = "G";
        3'd1:    r = "E";
        3'd2:    r = "T";
        3'd3:    r = " ";
        default: r = 8'h00;
      endcase
    end
    return r;
  endfunction

  // Header name pattern "content-length:" (lower case)
  function automatic logic [7:0] hdr_char(input logic [3:0] pos);
    logic [7:0] r;
    case (pos)
      4'd0:    r = "c";
      4'd1:    r = "o";
      4'd2:    r = "n";
      4'd3:    r = "t";
      4'd4:    r = "e";
      4'd5:    r = "n";
      4'd6:    r = "t";
      4'd7:    r = "-";
      4'd8:    r = "l";
      4'd9:    r = "e";
      4'd10:   r = "n";
      4'd11:   r = "g";
      4'd12:   r = "t";
      4'd13:   r = "h";
      4'd14:   r = ":";
      default: r = "c";
    endcase
    return r;
  endfunction

  // Blank line pattern CR LF CR LF
  function automatic logic [7:0] blank_char(input logic [1:0] pos);
    return pos[0] ? CH_LF : CH_CR;
  endfunction

endpackage

// File: hdl/http_request_framer_unit.sv
// HTTP request framer: marks request bytes, request ends and dropped bytes in a TCP byte stream.
// Pipeline: each byte is held in the input register, then the framing logic writes the result
//   register.
// Throughput: one byte per cycle while the result side is not stalled; the framing state updates once per byte.
// Stalls: a stalled result holds the input register, which then stalls the input side.
// Reset: rst_ni clears both valid flags and all framing state (idle, awaiting a method).
module http_request_framer_unit (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  hrf_pkg::in_t  in_data_i,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output hrf_pkg::out_t out_data_o
);
  import hrf_pkg::*;

  // Input register and handshake
  logic in_vld_q;
  in_t  in_q;
  logic advance;

  assign advance    = in_vld_q && (!out_valid_o || !out_stall_i);
  assign in_stall_o = in_vld_q && !advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (!in_stall_o) begin
      in_vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!in_stall_o && in_valid_i) begin
      in_q <= in_data_i;
    end
  end

  // Framing state
  stage_e               stage_q, stage_d;
  logic [2:0]           method_pos_q, method_pos_d;
  method_e              method_kind_q, method_kind_d;
  logic [1:0]           blank_q, blank_d;
  logic [3:0]           hdr_pos_q, hdr_pos_d;
  logic                 len_found_q, len_found_d;
  logic                 digits_open_q, digits_open_d;
  logic [LENGTH_BITS-1:0] content_len_q, content_len_d;
  logic [LENGTH_BITS-1:0] body_rem_q, body_rem_d;

  logic [7:0] c;
  logic       last;
  assign c    = in_q.data_byte;
  assign last = in_q.segment_last;

  // Method matcher
  logic [2:0] plen;
  logic       method_hit;
  logic       method_done;
  assign plen        = (method_kind_q == METHOD_POST) ? 3'd5 : 3'd4;
  assign method_hit  = (method_pos_q < plen) && (c == method_char(method_kind_q, method_pos_q));
  assign method_done = method_hit && ((method_pos_q + 3'd1) == plen);

  // Content-length matcher and digit accumulator (values as if in the header)
  logic                   hl_found;
  logic                   hl_open;
  logic [3:0]             hl_pos;
  logic [LENGTH_BITS-1:0] hl_len;
  logic [LENGTH_BITS+3:0] len_ext;
  logic [LENGTH_BITS+3:0] len_x10;
  logic [3:0]             hdr_p;
  logic [7:0]             lc;
  logic                   is_digit;

  assign lc       = to_lower(c);
  assign hdr_p    = (hdr_pos_q >= 4'(HDR_LEN)) ? 4'd0 : hdr_pos_q;
  assign is_digit = (c >= CH_ZERO) && (c <= CH_NINE);
  assign len_ext  = (LENGTH_BITS+4)'(content_len_q);
  assign len_x10  = (len_ext << 3) + (len_ext << 1) + (LENGTH_BITS+4)'(c - CH_ZERO);

  always_comb begin
    hl_found = len_found_q;
    hl_open  = digits_open_q;
    hl_pos   = hdr_pos_q;
    hl_len   = content_len_q;
    if (digits_open_q) begin
      if (is_digit) begin
        hl_len = (len_x10[LENGTH_BITS+3:LENGTH_BITS] != 4'd0) ? LEN_MAX
                                                              : len_x10[LENGTH_BITS-1:0];
      end else if (c == CH_LF) begin
        hl_open = 1'b0;
      end
    end else if (!len_found_q) begin
      // A failed byte is rechecked as a possible first pattern byte
      if (lc == hdr_char(hdr_p)) begin
        hl_pos = hdr_p + 4'd1;
      end else begin
        hl_pos = (lc == hdr_char(4'd0)) ? 4'd1 : 4'd0;
      end
      if (hl_pos == 4'(HDR_LEN)) begin
        hl_found = 1'b1;
        hl_open  = 1'b1;
        hl_len   = '0;
        hl_pos   = 4'd0;
      end
    end
  end

  // Blank line matcher
  logic [2:0] blank_next;
  logic       blank_done;
  logic       has_body;
  logic       body_last;
  assign blank_next = (c == blank_char(blank_q)) ? ({1'b0, blank_q} + 3'd1)
                    : ((c == CH_CR) ? 3'd1 : 3'd0);
  assign blank_done = (blank_next == 3'd4);
  assign has_body   = hl_found && (hl_len != '0);
  assign body_last  = (body_rem_q <= LENGTH_BITS'(1));

  // Saturated length for the result field
  logic [63:0]              len64;
  logic [BODY_LEN_BITS-1:0] len_out;
  assign len64   = 64'(hl_len);
  assign len_out = (len64 > 64'(LEN_MAX) || len64 > 64'hffff_ffff) && (len64 > 64'hffff_ffff)
                   ? '1 : len64[BODY_LEN_BITS-1:0];

  // Next stage
  always_comb begin
    stage_d = stage_q;
    case (stage_q)
      ST_METHOD: begin
        if (method_done) begin
          stage_d = ST_HEADER;
        end else if (!method_hit) begin
          stage_d = last ? ST_IDLE : ST_DROP;
        end
      end
      ST_HEADER: begin
        if (blank_done) begin
          stage_d = has_body ? ST_BODY : ST_IDLE;
        end
      end
      ST_BODY: begin
        if (body_last) begin
          stage_d = ST_IDLE;
        end
      end
      ST_DROP: begin
        if (last) begin
          stage_d = ST_IDLE;
        end
      end
      default: begin
        if (c == CH_G || c == CH_P) begin
          stage_d = ST_METHOD;
        end else begin
          stage_d = last ? ST_IDLE : ST_DROP;
        end
      end
    endcase
  end

  // Datapath state and result fields
  out_t res;
  always_comb begin
    method_pos_d  = method_pos_q;
    method_kind_d = method_kind_q;
    blank_d       = blank_q;
    hdr_pos_d     = hdr_pos_q;
    len_found_d   = len_found_q;
    digits_open_d = digits_open_q;
    content_len_d = content_len_q;
    body_rem_d    = body_rem_q;
    res.out_byte    = c;
    res.in_request  = 1'b0;
    res.request_end = 1'b0;
    res.dropped     = 1'b0;
    res.body_length = '0;
    case (stage_q)
      ST_METHOD: begin
        if (method_hit) begin
          method_pos_d = method_pos_q + 3'd1;
          if (method_done) begin
            method_pos_d   = 3'd0;
            blank_d        = 2'd0;
            hdr_pos_d      = 4'd0;
            len_found_d    = 1'b0;
            digits_open_d  = 1'b0;
            content_len_d  = '0;
            body_rem_d     = '0;
            res.in_request = 1'b1;
          end
        end else begin
          res.dropped  = 1'b1;
          method_pos_d = 3'd0;
        end
      end
      ST_HEADER: begin
        res.in_request = 1'b1;
        hdr_pos_d      = hl_pos;
        len_found_d    = hl_found;
        digits_open_d  = hl_open;
        content_len_d  = hl_len;
        if (blank_done) begin
          blank_d = 2'd0;
          if (has_body) begin
            body_rem_d = hl_len;
          end else begin
            res.request_end = 1'b1;
            res.body_length = hl_found ? len_out : '0;
          end
        end else begin
          blank_d = blank_next[1:0];
        end
      end
      ST_BODY: begin
        res.in_request = 1'b1;
        if (body_last) begin
          body_rem_d      = '0;
          res.request_end = 1'b1;
          res.body_length = len_out;
        end else begin
          body_rem_d = body_rem_q - LENGTH_BITS'(1);
        end
      end
      ST_DROP: begin
        res.dropped = 1'b1;
      end
      default: begin
        if (c == CH_G) begin
          method_kind_d = METHOD_GET;
          method_pos_d  = 3'd1;
        end else if (c == CH_P) begin
          method_kind_d = METHOD_POST;
          method_pos_d  = 3'd1;
        end else begin
          res.dropped  = 1'b1;
          method_pos_d = 3'd0;
        end
      end
    endcase
  end

  // State registers, updated once per byte
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stage_q       <= ST_IDLE;
      method_pos_q  <= 3'd0;
      method_kind_q <= METHOD_GET;
      blank_q       <= 2'd0;
      hdr_pos_q     <= 4'd0;
      len_found_q   <= 1'b0;
      digits_open_q <= 1'b0;
      content_len_q <= '0;
      body_rem_q    <= '0;
    end else if (advance) begin
      stage_q       <= stage_d;
      method_pos_q  <= method_pos_d;
      method_kind_q <= method_kind_d;
      blank_q       <= blank_d;
      hdr_pos_q     <= hdr_pos_d;
      len_found_q   <= len_found_d;
      digits_open_q <= digits_open_d;
      content_len_q <= content_len_d;
      body_rem_q    <= body_rem_d;
    end
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_o <= 1'b0;
    end else if (!out_valid_o || !out_stall_i) begin
      out_valid_o <= in_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_data_o <= res;
    end
  end

  // Checks
  a_req_drop_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(out_data_o.in_request && out_data_o.dropped))
    else $error("byte both in a request and dropped");

  a_end_in_req: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.request_end |-> out_data_o.in_request)
    else $error("request end outside a request");

  a_len_on_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.request_end |-> out_data_o.body_length == '0)
    else $error("body length set without request end");

  a_body_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stage_q == ST_BODY |-> body_rem_q != '0)
    else $error("body stage with no bytes remaining");

  a_hold_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_vld_q && !advance |=> in_vld_q && $stable(in_q))
    else $error("pending byte lost while stalled");

endmodule
